### hdl/ostt_pkg.sv
package ostt_pkg;

   localparam int SLOTS      = 8;
   localparam int QUANTUM_MS = 10;
   localparam int RES_MAX    = 8;

   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TIME_W   = 32;
   localparam int KEY_W    = 16;
   localparam int CMD_W    = 3;
   localparam int SEL_W    = 3;
   localparam int STATUS_W = 3;
   localparam int ID_W     = 3;
   localparam int CNT_W    = $clog2(RES_MAX + 1);

   // The quotient by the quantum is the top bits of the timeout times a rounded-up
   // reciprocal, which is exact for every 32-bit timeout.
   localparam int PROD_W  = 2 * TIME_W + 1;
   localparam int Q_SHIFT = $clog2(QUANTUM_MS);
   localparam logic [PROD_W-1:0] RECIP_FULL =
      ((PROD_W'(1) << (TIME_W + Q_SHIFT)) + PROD_W'(QUANTUM_MS - 1)) / PROD_W'(QUANTUM_MS);
   localparam logic [TIME_W:0] Q_RECIP = RECIP_FULL[TIME_W:0];

   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;

   localparam logic [STATUS_W-1:0] ST_CREATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUP     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ACK     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TIME_W-1:0] timeout_ms;
      logic [KEY_W-1:0]  owner_key;
      logic [SEL_W-1:0]  slot_sel;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     slot_id;
      logic [KEY_W-1:0]    expired_key;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic              apply;
      logic              mod_step;
      logic              scan_step;
      logic              tick_step;
      logic [SLOT_W-1:0] idx;
      logic              push_final;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             too_short;
      logic             tick_emit;
      logic             pend_valid;
      logic             out_free;
   } dp_stat_type;

endpackage

### hdl/ostt_dp.sv
module ostt_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  ostt_pkg::req_type    req,
   input  ostt_pkg::dp_cmd_type ctl,
   output ostt_pkg::dp_stat_type stat,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output ostt_pkg::rsp_type    rsp
);
   import ostt_pkg::*;

   localparam logic [TIME_W-1:0]  QUANT_T = TIME_W'(QUANTUM_MS);

   req_type             req_ff, req_in;
   logic [SLOTS-1:0]    live_ff, live_in;
   logic [SLOTS-1:0]    en_ff, en_in;
   logic [TIME_W-1:0]   rem_ff [SLOTS];
   logic [TIME_W-1:0]   rem_in [SLOTS];
   logic [KEY_W-1:0]    key_ff [SLOTS];
   logic [KEY_W-1:0]    key_in [SLOTS];
   logic [TIME_W-1:0]   quot_ff, quot_in;
   logic                dup_ff, dup_in;
   logic                free_ff, free_in;
   logic [SLOT_W-1:0]   free_idx_ff, free_idx_in;
   logic                pend_valid_ff, pend_valid_in;
   rsp_type             pend_ff, pend_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [TIME_W-1:0]   rem_rd;
   logic [KEY_W-1:0]    key_rd;
   logic                live_rd;
   logic                en_rd;
   logic                tick_emit;
   logic [PROD_W-1:0]   prod;
   logic [TIME_W-1:0]   rounded;
   logic                sel_ok;
   logic [SLOT_W-1:0]   sel_idx;
   logic                too_short;
   rsp_type             final_rsp;

   always_comb begin
      rem_rd    = rem_ff[ctl.idx];
      key_rd    = key_ff[ctl.idx];
      live_rd   = live_ff[ctl.idx];
      en_rd     = en_ff[ctl.idx];
      tick_emit = live_rd && (rem_rd == '0) && en_rd && (cnt_ff < CNT_W'(RES_MAX));
      prod      = PROD_W'(req_ff.timeout_ms) * PROD_W'(Q_RECIP);
      rounded   = quot_ff * QUANT_T;
      sel_ok    = 32'(req_ff.slot_sel) < SLOTS;
      sel_idx   = SLOT_W'(req_ff.slot_sel);
      too_short = req_ff.timeout_ms < QUANT_T;
   end

   always_comb begin
      final_rsp      = '0;
      final_rsp.last = 1'b1;
      unique case (req_ff.cmd)
         CMD_CREATE: begin
            if (too_short) begin
               final_rsp.status = ST_SHORT;
            end else if (dup_ff) begin
               final_rsp.status = ST_DUP;
            end else if (free_ff) begin
               final_rsp.status  = ST_CREATED;
               final_rsp.slot_id = ID_W'(free_idx_ff);
            end else begin
               final_rsp.status = ST_FULL;
            end
         end
         CMD_TICK: begin
            if (pend_valid_ff) begin
               final_rsp      = pend_ff;
               final_rsp.last = 1'b1;
            end else begin
               final_rsp.status = ST_NONE;
            end
         end
         default: begin
            final_rsp.status = ST_ACK;
         end
      endcase
   end

   always_comb begin
      req_in        = req_ff;
      live_in       = live_ff;
      en_in         = en_ff;
      rem_in        = rem_ff;
      key_in        = key_ff;
      quot_in       = quot_ff;
      dup_in        = dup_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      if (ctl.load) begin
         req_in        = req;
         dup_in        = 1'b0;
         free_in       = 1'b0;
         pend_valid_in = 1'b0;
         cnt_in        = '0;
      end

      if (ctl.apply) begin
         unique case (req_ff.cmd)
            CMD_CLEAR: begin
               live_in = '0;
               en_in   = '0;
            end
            CMD_STOP: begin
               if (sel_ok) begin
                  live_in[sel_idx] = 1'b0;
               end
            end
            CMD_DISABLE: begin
               if (sel_ok) begin
                  en_in[sel_idx] = 1'b0;
               end
            end
            CMD_ENABLE: begin
               if (sel_ok) begin
                  en_in[sel_idx] = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (ctl.mod_step) begin
         quot_in = TIME_W'(prod >> (TIME_W + Q_SHIFT));
      end

      if (ctl.scan_step) begin
         if ((req_ff.owner_key != '0) && live_rd && (key_rd == req_ff.owner_key)) begin
            dup_in = 1'b1;
         end
         if (!live_rd && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = ctl.idx;
         end
      end

      if (ctl.tick_step && live_rd) begin
         if (rem_rd != '0) begin
            if (rem_rd < QUANT_T) begin
               rem_in[ctl.idx] = '0;
            end else begin
               rem_in[ctl.idx] = rem_rd - QUANT_T;
            end
         end else if (tick_emit) begin
            live_in[ctl.idx] = 1'b0;
            if (pend_valid_ff) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
            end
            pend_valid_in       = 1'b1;
            pend_in.status      = ST_EXPIRED;
            pend_in.slot_id     = ID_W'(ctl.idx);
            pend_in.expired_key = key_rd;
            pend_in.last        = 1'b0;
            cnt_in              = cnt_ff + 1'b1;
         end
      end

      if (ctl.push_final) begin
         rsp_in       = final_rsp;
         rsp_valid_in = 1'b1;
         if ((req_ff.cmd == CMD_CREATE) && (final_rsp.status == ST_CREATED)) begin
            rem_in[free_idx_ff]  = rounded;
            key_in[free_idx_ff]  = req_ff.owner_key;
            live_in[free_idx_ff] = 1'b1;
            en_in[free_idx_ff]   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff       <= '0;
         en_ff         <= '0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         live_ff       <= live_in;
         en_ff         <= en_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rem_ff      <= rem_in;
      key_ff      <= key_in;
      quot_ff     <= quot_in;
      dup_ff      <= dup_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign stat.cmd        = req_ff.cmd;
   assign stat.too_short  = too_short;
   assign stat.tick_emit  = tick_emit;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### hdl/ostt_ctrl.sv
module ostt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ostt_pkg::dp_stat_type stat,
   output ostt_pkg::dp_cmd_type  ctl
);
   import ostt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_MOD    = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_TICK   = 3'd4;
   localparam logic [2:0] S_FINAL  = 3'd5;

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      ctl         = '0;
      ctl.idx     = idx_ff;
      req_stall   = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.cmd)
               CMD_CREATE: begin
                  if (stat.too_short) begin
                     state_in = S_FINAL;
                  end else begin
                     state_in = S_MOD;
                  end
               end
               CMD_TICK: begin
                  idx_in   = '0;
                  state_in = S_TICK;
               end
               default: begin
                  ctl.apply = 1'b1;
                  state_in  = S_FINAL;
               end
            endcase
         end
         S_MOD: begin
            ctl.mod_step = 1'b1;
            idx_in       = '0;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_FINAL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TICK: begin
            if (!(stat.tick_emit && stat.pend_valid && !stat.out_free)) begin
               ctl.tick_step = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = S_FINAL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               ctl.push_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### hdl/one_shot_timer_table_top.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   ostt_pkg::req_type
// rsp       out        rsp_valid/rsp_stall   ostt_pkg::rsp_type
//
// Clear, stop, disable, enable, unknown commands and a too-short create go from decode to the final result.
// A create first forms the quotient by the quantum with a reciprocal multiply,
// then the table is scanned one slot per cycle.
// A tick scans the table one slot per cycle, except while an expiry waits for the output.
// Every item also waits in its final state while the result before it is stalled on rsp.
// Reset is synchronous and frees and disables every slot; there is no clearing pass.
module one_shot_timer_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ostt_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ostt_pkg::rsp_type rsp
);
   import ostt_pkg::*;

   dp_cmd_type  ctl;
   dp_stat_type stat;

   ostt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   ostt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

### hdl/ostt_checker.sv
module ostt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ostt_pkg::rsp_type rsp
);
   import ostt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("Stalled result changed or dropped.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Input accepted again right after an item.");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != ST_EXPIRED) |-> rsp.last)
      else $error("Single-result item without last.");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != ST_EXPIRED) && (rsp.status != ST_CREATED)
      |-> (rsp.slot_id == '0) && (rsp.expired_key == '0))
      else $error("Unused result fields are not zero.");

endmodule

bind one_shot_timer_table_top ostt_checker u_ostt_checker (.*);
